>>> rtl/core/htfs_pkg.sv
// ----------------------------------------------------------------------------
// htfs_pkg
// Shared types and constants for the handle table with free-index stack.
// ----------------------------------------------------------------------------
package htfs_pkg;

    localparam int SLOT_W    = 12;
    localparam int SLOTS     = 1 << SLOT_W;
    localparam int DEPTH_W   = SLOT_W + 1;
    localparam int FUNC_W    = 3;
    localparam int STATUS_W  = 3;
    localparam int HANDLE_W  = 32;

    localparam int PAGE_SLOTS_DEF  = 256;
    localparam int MAX_PAGES_DEF   = 16;
    localparam int HANDLE_BITS_DEF = 32;

    // request codes
    localparam logic [FUNC_W-1:0] FN_ALLOC  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_BIND   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_REBIND = 3'd2;
    localparam logic [FUNC_W-1:0] FN_FIND   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_UNBIND = 3'd4;

    // response status codes
    localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STS_BEYOND   = 3'd1;
    localparam logic [STATUS_W-1:0] STS_OCCUPIED = 3'd2;
    localparam logic [STATUS_W-1:0] STS_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] STS_FULL     = 3'd4;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [SLOT_W-1:0]   slot_index;
        logic [HANDLE_W-1:0] handle_in;
    } t_req;

    typedef struct packed {
        logic                ok;
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   index_out;
        logic [HANDLE_W-1:0] handle_out;
        logic [HANDLE_W-1:0] replaced_handle;
    } t_rsp;

endpackage

>>> rtl/core/htfs_ram.sv
// ----------------------------------------------------------------------------
// htfs_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module htfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/handle_table_with_free_stack.sv
// ----------------------------------------------------------------------------
// handle_table_with_free_stack
// Handle table with a LIFO of freed indices and page-wise capacity growth.
// ----------------------------------------------------------------------------
// One request channel (i_req_valid / o_req_ready / i_req) carries allocate,
// bind, rebind, find and unbind requests; one response channel (o_rsp_valid /
// i_rsp_ready / o_rsp) returns exactly one response per request, in order.
// A request is first accepted, then evaluated: the accept cycle reads the
// slot RAM and the free-stack RAM, the evaluate cycle evaluates, writes back
// and loads the response register. No new request is accepted before the
// last one is evaluated, as the slot RAM read in the read-modify-write loop
// is registered. A response is visible in the cycle after its evaluate cycle.
// After reset the slot RAM is swept to zero, one entry per cycle, over all
// SLOTS (4096) entries; o_req_ready stays low during the sweep.
// A new request is accepted while a response still waits in the output
// register; if the receiver keeps stalling, the evaluate cycle holds until
// the response register frees, and no further request is accepted meanwhile.
// ----------------------------------------------------------------------------
module handle_table_with_free_stack #(
    parameter int PAGE_SLOTS  = htfs_pkg::PAGE_SLOTS_DEF,
    parameter int MAX_PAGES   = htfs_pkg::MAX_PAGES_DEF,
    parameter int HANDLE_BITS = htfs_pkg::HANDLE_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  htfs_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output htfs_pkg::t_rsp o_rsp
);

    localparam int SLOT_W  = htfs_pkg::SLOT_W;
    localparam int DEPTH_W = htfs_pkg::DEPTH_W;
    localparam int HW      = htfs_pkg::HANDLE_W;
    localparam int SLOTS   = htfs_pkg::SLOTS;
    localparam int CAP_MAX = PAGE_SLOTS * MAX_PAGES;
    localparam int FRESH_LIMIT = (CAP_MAX > SLOTS) ? SLOTS : CAP_MAX;
    localparam int CAP_W   = $clog2(CAP_MAX + 1);
    localparam int CMP_W   = (CAP_W > SLOT_W) ? CAP_W : SLOT_W;
    localparam int PG_W    = $clog2(MAX_PAGES + 1);
    localparam int SW      = (HANDLE_BITS < HW) ? HANDLE_BITS : HW;

    htfs_pkg::t_state r_state, n_state;
    htfs_pkg::t_req   r_req;
    htfs_pkg::t_rsp   r_rsp, n_rsp;
    logic             r_rsp_valid, n_rsp_valid;

    logic [SLOT_W-1:0]  r_clr;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [DEPTH_W-1:0] r_fresh, n_fresh;
    logic [PG_W-1:0]    r_pages, n_pages;
    logic [CAP_W-1:0]   r_cap, n_cap;

    logic               accept;
    logic               can_done;
    logic [DEPTH_W-1:0] depth_m1;

    logic               slot_we;
    logic [SLOT_W-1:0]  slot_waddr;
    logic [SW-1:0]      slot_wdata;
    logic [SW-1:0]      slot_rdata;
    logic               stk_we;
    logic [SLOT_W-1:0]  stk_rdata;

    // evaluate-cycle helpers
    logic [SW-1:0]      h;
    logic               beyond;
    logic               cur_zero;
    logic [SLOT_W-1:0]  grant;
    logic               have;

    assign accept   = i_req_valid && o_req_ready;
    assign depth_m1 = r_depth - DEPTH_W'(1);
    assign can_done = !r_rsp_valid || i_rsp_ready;

    htfs_ram #(
        .WIDTH (SW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_re    (accept),
        .i_raddr (i_req.slot_index),
        .o_rdata (slot_rdata)
    );

    htfs_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_depth[SLOT_W-1:0]),
        .i_wdata (r_req.slot_index),
        .i_re    (accept),
        .i_raddr (depth_m1[SLOT_W-1:0]),
        .o_rdata (stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= htfs_pkg::S_CLEAR;
            r_clr       <= '0;
            r_rsp_valid <= 1'b0;
            r_depth     <= '0;
            r_fresh     <= '0;
            r_pages     <= PG_W'(1);
            r_cap       <= CAP_W'(PAGE_SLOTS);
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
            r_depth     <= n_depth;
            r_fresh     <= n_fresh;
            r_pages     <= n_pages;
            r_cap       <= n_cap;
            if (r_state == htfs_pkg::S_CLEAR) begin
                r_clr <= r_clr + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (r_state == htfs_pkg::S_EXEC && can_done) begin
            r_rsp <= n_rsp;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_rsp_valid = r_rsp_valid;
        n_rsp       = '0;
        n_depth     = r_depth;
        n_fresh     = r_fresh;
        n_pages     = r_pages;
        n_cap       = r_cap;
        o_req_ready = 1'b0;
        slot_we     = 1'b0;
        slot_waddr  = r_req.slot_index;
        slot_wdata  = '0;
        stk_we      = 1'b0;

        h        = r_req.handle_in[SW-1:0];
        beyond   = CMP_W'(r_req.slot_index) >= CMP_W'(r_cap);
        cur_zero = (slot_rdata == '0);
        have     = 1'b1;
        grant    = '0;

        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end

        case (r_state)
            htfs_pkg::S_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = r_clr;
                if (r_clr == '1) begin
                    n_state = htfs_pkg::S_IDLE;
                end
            end
            htfs_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_state = htfs_pkg::S_EXEC;
                end
            end
            htfs_pkg::S_EXEC: begin
                if (can_done) begin
                    n_state     = htfs_pkg::S_IDLE;
                    n_rsp_valid = 1'b1;
                    case (r_req.func)
                        htfs_pkg::FN_ALLOC: begin
                            if (r_depth != '0) begin
                                n_depth = depth_m1;
                                grant   = stk_rdata;
                            end else if (r_fresh < DEPTH_W'(FRESH_LIMIT)) begin
                                grant   = r_fresh[SLOT_W-1:0];
                                n_fresh = r_fresh + DEPTH_W'(1);
                            end else begin
                                have = 1'b0;
                            end
                            if (have) begin
                                // grow by one page when the grant lies past capacity and a page is left
                                if (CMP_W'(grant) >= CMP_W'(r_cap)
                                        && r_pages < PG_W'(MAX_PAGES)) begin
                                    n_pages = r_pages + PG_W'(1);
                                    n_cap   = r_cap + CAP_W'(PAGE_SLOTS);
                                end
                                n_rsp.ok        = 1'b1;
                                n_rsp.index_out = grant;
                            end else begin
                                n_rsp.status = htfs_pkg::STS_FULL;
                            end
                        end
                        htfs_pkg::FN_BIND: begin
                            if (beyond) begin
                                n_rsp.status = htfs_pkg::STS_BEYOND;
                            end else if (!cur_zero) begin
                                n_rsp.status = htfs_pkg::STS_OCCUPIED;
                            end else begin
                                slot_we    = 1'b1;
                                slot_wdata = h;
                                n_rsp.ok   = 1'b1;
                            end
                        end
                        htfs_pkg::FN_REBIND: begin
                            if (beyond) begin
                                n_rsp.status = htfs_pkg::STS_BEYOND;
                            end else begin
                                slot_we               = 1'b1;
                                slot_wdata            = h;
                                n_rsp.ok              = 1'b1;
                                n_rsp.replaced_handle = HW'(slot_rdata);
                            end
                        end
                        htfs_pkg::FN_FIND: begin
                            if (beyond) begin
                                n_rsp.status = htfs_pkg::STS_BEYOND;
                            end else if (cur_zero) begin
                                n_rsp.status = htfs_pkg::STS_EMPTY;
                            end else begin
                                n_rsp.ok         = 1'b1;
                                n_rsp.handle_out = HW'(slot_rdata);
                            end
                        end
                        htfs_pkg::FN_UNBIND: begin
                            if (beyond) begin
                                n_rsp.status = htfs_pkg::STS_BEYOND;
                            end else if (cur_zero) begin
                                n_rsp.status = htfs_pkg::STS_EMPTY;
                            end else begin
                                slot_we          = 1'b1;
                                n_rsp.ok         = 1'b1;
                                n_rsp.handle_out = HW'(slot_rdata);
                                // push dropped once the stack is full
                                if (!r_depth[DEPTH_W-1]) begin
                                    stk_we  = 1'b1;
                                    n_depth = r_depth + DEPTH_W'(1);
                                end
                            end
                        end
                        default: begin
                            n_rsp = '0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = htfs_pkg::S_IDLE;
            end
        endcase
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule
